// ===== hw/rtl/motion_alarm_scheduler_assert.svh =====
// Assertion macros for the motion alarm scheduler.
`ifndef MOTION_ALARM_SCHEDULER_ASSERT_SVH
`define MOTION_ALARM_SCHEDULER_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define MAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define MAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mas_pkg.sv =====
// Shared types, constants and helpers of the motion alarm scheduler.
package mas_pkg;

  localparam int unsigned SCHED_ENTRIES = 8;
  localparam int unsigned MINUTE_W      = 11;
  localparam int unsigned HOLD_W        = 16;
  localparam int unsigned RESEND_W      = 8;
  localparam int unsigned DAY_W         = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned IN_DATA_W     = 64;
  localparam int unsigned OUT_DATA_W    = 8;

  localparam logic [RESEND_W-1:0] RESEND_RESET = 8'd30;
  localparam logic [HOLD_W-1:0]   DETECT_LIMIT = 16'd2;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    CODE_NONE     = 2'd0,
    CODE_DETECTED = 2'd1,
    CODE_RESUMED  = 2'd2
  } alarm_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_EN = 2'd0,
    CFG_HOLD      = 2'd1,
    CFG_RESEND    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                enable;
    logic [MINUTE_W-1:0] s1;
    logic [MINUTE_W-1:0] e1;
    logic [MINUTE_W-1:0] s2;
    logic [MINUTE_W-1:0] e2;
  } sched_entry_t;

  typedef struct packed {
    logic         valid;
    logic [2:0]   idx;
    sched_entry_t entry;
  } sched_wr_t;

  typedef struct packed {
    logic [HOLD_W-1:0]   hold_seconds;
    logic [RESEND_W-1:0] resend_seconds;
  } alarm_cfg_t;

  typedef struct packed {
    logic                action;
    logic                motion_seen;
    logic [DAY_W-1:0]    day_of_week;
    logic [MINUTE_W-1:0] minute_of_day;
    logic [2:0]          entry_index;
    sched_entry_t        entry;
  } in_item_t;

  // Inclusive two-window match; an inverted window matches nothing.
  function automatic logic entry_hits(sched_entry_t e, logic [MINUTE_W-1:0] m);
    logic w1;
    logic w2;
    w1 = (m >= e.s1) && (m <= e.e1);
    w2 = (m >= e.s2) && (m <= e.e2);
    return e.enable && (w1 || w2);
  endfunction

endpackage

// ===== hw/rtl/mas_sched.sv =====
// Schedule table and window lookup of the motion alarm scheduler.
module mas_sched #(
  parameter int unsigned SchedEntries = mas_pkg::SCHED_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mas_pkg::sched_wr_t            wr_i,
  input  logic                          detect_en_i,
  input  logic [mas_pkg::DAY_W-1:0]     day_i,
  input  logic [mas_pkg::MINUTE_W-1:0]  minute_i,
  output logic                          hit_o
);
  import mas_pkg::*;

  localparam int unsigned IdxW = $clog2(SchedEntries);
  localparam logic [IdxW-1:0] EverydayIdx = IdxW'(SchedEntries - 1);

  logic [SchedEntries-1:0] enable_q;
  sched_entry_t            bounds_q [SchedEntries];
  sched_entry_t            day_entry;
  sched_entry_t            all_entry;
  logic [IdxW-1:0]         wr_idx;
  logic [IdxW-1:0]         day_idx;

  assign wr_idx  = wr_i.idx[IdxW-1:0];
  assign day_idx = day_i[IdxW-1:0];

  // Enable bits clear at reset; bounds of a disabled entry never matter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (wr_i.valid) begin
      enable_q[wr_idx] <= wr_i.entry.enable;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      bounds_q[wr_idx] <= wr_i.entry;
    end
  end

  always_comb begin
    day_entry        = bounds_q[day_idx];
    day_entry.enable = enable_q[day_idx];
    all_entry        = bounds_q[EverydayIdx];
    all_entry.enable = enable_q[EverydayIdx];
  end

  assign hit_o = detect_en_i &&
                 (entry_hits(day_entry, minute_i) || entry_hits(all_entry, minute_i));

endmodule

// ===== hw/rtl/mas_alarm.sv =====
// Rate limiter and hold timer state of the motion alarm scheduler.
module mas_alarm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 motion_i,
  input  logic                 hit_i,
  input  mas_pkg::alarm_cfg_t  cfg_i,
  output mas_pkg::alarm_code_e code_o
);
  import mas_pkg::*;

  logic                pending_q, pending_d;
  logic [RESEND_W-1:0] resend_q, resend_d;
  logic [HOLD_W-1:0]   hold_q, hold_d;
  logic                owed_q, owed_d;
  logic                pend_mid;
  logic [RESEND_W-1:0] resend_mid;
  logic [HOLD_W-1:0]   hold_dec;

  always_comb begin
    // Rate limiter: raise the flag at most once per resend period.
    pend_mid   = pending_q;
    resend_mid = resend_q;
    if (motion_i && (resend_q == '0)) begin
      pend_mid   = 1'b1;
      resend_mid = cfg_i.resend_seconds;
    end
    resend_d = (resend_mid != '0) ? resend_mid - 1'b1 : '0;

    hold_dec  = (hold_q != '0) ? hold_q - 1'b1 : '0;
    pending_d = pend_mid;
    hold_d    = hold_q;
    owed_d    = owed_q;
    code_o    = CODE_NONE;
    if (hit_i) begin
      if (pend_mid) begin
        if (hold_q <= DETECT_LIMIT) code_o = CODE_DETECTED;
        hold_d    = cfg_i.hold_seconds;
        owed_d    = 1'b1;
        pending_d = 1'b0;
      end else begin
        hold_d = hold_dec;
        if ((hold_dec == '0) && owed_q) begin
          owed_d = 1'b0;
          code_o = CODE_RESUMED;
        end
      end
    end else begin
      // Out of schedule: drop the flag, resume a running hold.
      pending_d = 1'b0;
      if (hold_q != '0) begin
        code_o = CODE_RESUMED;
        hold_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      resend_q  <= '0;
      hold_q    <= '0;
      owed_q    <= 1'b0;
    end else if (tick_i) begin
      pending_q <= pending_d;
      resend_q  <= resend_d;
      hold_q    <= hold_d;
      owed_q    <= owed_d;
    end
  end

endmodule

// ===== hw/rtl/motion_alarm_scheduler.sv =====
// Top level of the one-channel motion alarm scheduler.
//
// Usage: requests arrive on the s_axis group, one per accepted beat. tuser
// selects the kind: a one-second tick or a schedule entry write. Each
// request gives exactly one result on the m_axis group: the alarm code
// (none, detected, resumed) and whether the tick's minute lay in an enabled
// window. A write request returns a result of all zeros.
// Timing: a request taken into the input register is evaluated there
// against the schedule table and the timers, and its result is
// registered into the result register when that register is free or
// being drained.
// Throughput: one request every cycle while the result register is free
// or drained; the timers and flags update on the same edge as the result.
// Stalls: while m_axis_tready is low the result register holds and the
// input register may still take one more request; s_axis_tready drops
// only when both registers are full.
// Configuration: cfg_we_i writes register cfg_idx_i (0 enable, 1 hold
// seconds, 2 resend seconds); write only while the block is idle.
// Reset: clears both valid bits, the timers and flags, disables every
// schedule entry, and sets resend seconds to 30.
module motion_alarm_scheduler #(
  parameter int unsigned SchedEntries = mas_pkg::SCHED_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata from bit 0: motion_seen, day_of_week[3], minute_of_day[11],
  // entry_index[3], entry_enable, first_start[11], first_end[11],
  // second_start[11], second_end[11], one zero pad bit
  input  logic [mas_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: action
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata from bit 0: alarm_code[2], in_schedule, five zero pad bits
  output logic [mas_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [mas_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mas_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mas_pkg::*;
  `include "motion_alarm_scheduler_assert.svh"

  // Configuration registers.
  logic       detect_en_q;
  alarm_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_en_q          <= 1'b0;
      cfg_q.hold_seconds   <= '0;
      cfg_q.resend_seconds <= RESEND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DETECT_EN: detect_en_q          <= cfg_data_i[0];
        CFG_HOLD:      cfg_q.hold_seconds   <= cfg_data_i[HOLD_W-1:0];
        CFG_RESEND:    cfg_q.resend_seconds <= cfg_data_i[RESEND_W-1:0];
        default:       ;
      endcase
    end
  end

  // Input register.
  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_q;
  in_item_t in_item;
  logic     in_acc;
  logic     s1_adv;
  logic     m_valid_q, m_valid_d;

  assign in_item.action        = s_axis_tuser;
  assign in_item.motion_seen   = s_axis_tdata[0];
  assign in_item.day_of_week   = s_axis_tdata[3:1];
  assign in_item.minute_of_day = s_axis_tdata[14:4];
  assign in_item.entry_index   = s_axis_tdata[17:15];
  assign in_item.entry.enable  = s_axis_tdata[18];
  assign in_item.entry.s1      = s_axis_tdata[29:19];
  assign in_item.entry.e1      = s_axis_tdata[40:30];
  assign in_item.entry.s2      = s_axis_tdata[51:41];
  assign in_item.entry.e2      = s_axis_tdata[62:52];

  // Advance when the result register is empty or being drained.
  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc)      s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= s1_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= in_item;
  end

  // Evaluation of the held request.
  sched_wr_t   sched_wr;
  logic        hit;
  logic        tick_adv;
  alarm_code_e alarm_code;

  assign sched_wr.valid = s1_adv && (s1_q.action == ACT_WRITE);
  assign sched_wr.idx   = s1_q.entry_index;
  assign sched_wr.entry = s1_q.entry;
  assign tick_adv       = s1_adv && (s1_q.action == ACT_TICK);

  mas_sched #(
    .SchedEntries(SchedEntries)
  ) u_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (sched_wr),
    .detect_en_i(detect_en_q),
    .day_i      (s1_q.day_of_week),
    .minute_i   (s1_q.minute_of_day),
    .hit_o      (hit)
  );

  mas_alarm u_alarm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_adv),
    .motion_i(s1_q.motion_seen),
    .hit_i   (hit),
    .cfg_i   (cfg_q),
    .code_o  (alarm_code)
  );

  // Result register.
  logic [1:0] code_q;
  logic       in_sched_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (s1_adv)             m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else         m_valid_q <= m_valid_d;
  end

  // A write request reports no alarm and no schedule hit.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      code_q     <= (s1_q.action == ACT_WRITE) ? CODE_NONE : alarm_code;
      in_sched_q <= (s1_q.action == ACT_WRITE) ? 1'b0 : hit;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, in_sched_q, code_q};

  `MAS_ASSERT_NEXT(a_write_result_zero, s1_adv && (s1_q.action == ACT_WRITE),
                   m_valid_q && (code_q == CODE_NONE) && !in_sched_q,
                   "write request gave a nonzero result")
  `MAS_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, s1_valid_q && m_valid_q,
                  "input stalled with a free register")
  `MAS_ASSERT_NOW(a_code_legal, m_valid_q, code_q != 2'd3, "illegal alarm code")
  `MAS_ASSERT_NEXT(a_no_hit_when_disabled, s1_adv && !detect_en_q, !in_sched_q,
                   "in schedule reported while detection disabled")

endmodule
